// ===== rtl/twdm_pkg.sv =====
// ----------------------------------------------------------------------------
// twdm_pkg
// Types, command codes and opcode bytes for the two-wire debug master.
// ----------------------------------------------------------------------------
package twdm_pkg;

	// input item opcode
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} item_op_t;

	typedef enum logic [3:0] {
		CMD_ENTRY  = 4'd0,
		CMD_ERASE  = 4'd1,
		CMD_WRCFG  = 4'd2,
		CMD_STATUS = 4'd3,
		CMD_CHIPID = 4'd4,
		CMD_HALT   = 4'd5,
		CMD_RESUME = 4'd6,
		CMD_INSTR  = 4'd7,
		CMD_STEP   = 4'd8,
		CMD_PC     = 4'd9
	} cmd_t;

	localparam logic [7:0] OPB_ERASE  = 8'h14;
	localparam logic [7:0] OPB_WRCFG  = 8'h1d;
	localparam logic [7:0] OPB_STATUS = 8'h34;
	localparam logic [7:0] OPB_CHIPID = 8'h68;
	localparam logic [7:0] OPB_HALT   = 8'h44;
	localparam logic [7:0] OPB_RESUME = 8'h4c;
	localparam logic [7:0] OPB_INSTR  = 8'h54;
	localparam logic [7:0] OPB_STEP   = 8'h5c;
	localparam logic [7:0] OPB_PC     = 8'h28;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ENTRY = 2'd1,
		ST_SEND  = 2'd2,
		ST_RECV  = 2'd3
	} stage_t;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  command_code;
		logic [7:0]  config_value;
		logic [23:0] instruction_bytes;
		logic [1:0]  instruction_length;
		logic        data_sample;
	} in_item_t;

	typedef struct packed {
		logic        reset_pin;
		logic        clock_pin;
		logic        data_pin;
		logic        data_drive;
		logic        busy_res;
		logic        reply_valid;
		logic [15:0] reply;
	} out_item_t;

	typedef struct packed {
		logic        reset_level;
		logic        clock_level;
		logic        data_level;
		logic        drive_enable;
		stage_t      stage;
		logic [2:0]  phase;
		logic [7:0]  tick_div;
		logic [2:0]  bit_idx;
		logic [2:0]  byte_idx;
		logic [31:0] send_buf;
		logic [2:0]  send_count;
		logic [15:0] recv_shift;
		logic [1:0]  recv_count;
	} twdm_state_t;

	// reset line released high, everything else cleared
	localparam twdm_state_t STATE_RESET = '{reset_level: 1'b1, stage: ST_IDLE, default: '0};

	function automatic logic [7:0] cmd_opbyte(logic [3:0] cmd);
		logic [7:0] b;
		case (cmd)
			CMD_ERASE:  b = OPB_ERASE;
			CMD_WRCFG:  b = OPB_WRCFG;
			CMD_STATUS: b = OPB_STATUS;
			CMD_CHIPID: b = OPB_CHIPID;
			CMD_HALT:   b = OPB_HALT;
			CMD_RESUME: b = OPB_RESUME;
			CMD_INSTR:  b = OPB_INSTR;
			CMD_STEP:   b = OPB_STEP;
			CMD_PC:     b = OPB_PC;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/twdm_step.sv =====
// ----------------------------------------------------------------------------
// twdm_step
// Next-state and result logic for one item: command start or one tick.
// ----------------------------------------------------------------------------
module twdm_step import twdm_pkg::*; (
	input  twdm_state_t cur,
	input  logic [7:0]  ticks,
	input  in_item_t    item,
	output twdm_state_t nxt,
	output out_item_t   res
);

	// pin action for the current stage and phase
	function automatic twdm_state_t do_action(twdm_state_t s, logic sample);
		twdm_state_t r;
		logic [4:0]  pos;
		r = s;
		pos = {s.byte_idx[1:0], s.bit_idx};
		unique case (s.stage)
			ST_ENTRY: begin
				case (s.phase)
					3'd0:       r.reset_level = 1'b0;
					3'd1, 3'd3: r.clock_level = 1'b1;
					3'd2, 3'd4: r.clock_level = 1'b0;
					default:    r.reset_level = 1'b1;
				endcase
			end
			ST_SEND: begin
				if (s.phase == 3'd0) begin
					r.drive_enable = 1'b1;
					r.data_level   = s.send_buf[~pos];
				end else if (s.phase == 3'd1) begin
					r.clock_level = 1'b1;
				end else begin
					r.clock_level = 1'b0;
				end
			end
			ST_RECV: begin
				if (s.phase == 3'd0) begin
					r.drive_enable = 1'b0;
					r.clock_level  = 1'b1;
				end else if (s.phase == 3'd1) begin
					r.recv_shift = {s.recv_shift[14:0], sample};
				end else begin
					r.clock_level = 1'b0;
				end
			end
			ST_IDLE: ;
		endcase
		return r;
	endfunction

	logic        done;
	logic        act;
	logic [7:0]  limit;
	logic [7:0]  tdiv;
	logic [7:0]  opb;
	logic [15:0] reply;

	always_comb begin
		nxt   = cur;
		done  = 1'b0;
		act   = 1'b0;
		reply = '0;
		limit = (ticks == 8'd0) ? 8'd1 : ticks;
		tdiv  = cur.tick_div + 8'd1;
		opb   = cmd_opbyte(item.command_code);

		if (item.opcode == OP_START) begin
			// commands are dropped while busy or when the code is unknown
			if (cur.stage == ST_IDLE && item.command_code <= CMD_PC) begin
				nxt.phase      = '0;
				nxt.bit_idx    = '0;
				nxt.byte_idx   = '0;
				nxt.tick_div   = '0;
				nxt.recv_shift = '0;
				if (item.command_code == CMD_ENTRY) begin
					nxt.stage = ST_ENTRY;
				end else begin
					nxt.send_count = 3'd1;
					if (item.command_code == CMD_WRCFG) begin
						nxt.send_buf   = {opb, item.config_value, 16'h0000};
						nxt.send_count = 3'd2;
					end else if (item.command_code == CMD_INSTR) begin
						nxt.send_buf   = {opb | {6'd0, item.instruction_length},
							item.instruction_bytes};
						nxt.send_count = 3'd1 + {1'b0, item.instruction_length};
					end else begin
						nxt.send_buf = {opb, 24'h000000};
					end
					nxt.recv_count = (item.command_code == CMD_CHIPID ||
						item.command_code == CMD_PC) ? 2'd2 : 2'd1;
					nxt.stage = ST_SEND;
				end
				act = 1'b1;
			end
		end else if (cur.stage != ST_IDLE) begin
			nxt.tick_div = tdiv;
			if (tdiv >= limit) begin
				nxt.tick_div = '0;
				unique case (cur.stage)
					ST_ENTRY: begin
						if (cur.phase >= 3'd5) begin
							done = 1'b1;
						end else begin
							nxt.phase = cur.phase + 3'd1;
							act = 1'b1;
						end
					end
					ST_SEND, ST_RECV: begin
						act = 1'b1;
						if (cur.phase < 3'd2) begin
							nxt.phase = cur.phase + 3'd1;
						end else begin
							nxt.phase = '0;
							if (cur.bit_idx < 3'd7) begin
								nxt.bit_idx = cur.bit_idx + 3'd1;
							end else begin
								nxt.bit_idx  = '0;
								nxt.byte_idx = cur.byte_idx + 3'd1;
								if (cur.stage == ST_SEND) begin
									if (nxt.byte_idx >= cur.send_count) begin
										nxt.stage    = ST_RECV;
										nxt.byte_idx = '0;
									end
								end else if (nxt.byte_idx >= {1'b0, cur.recv_count}) begin
									done = 1'b1;
									act  = 1'b0;
								end
							end
						end
					end
					ST_IDLE: ;
				endcase
			end
		end

		if (act) begin
			nxt = do_action(nxt, item.data_sample);
		end
		if (done) begin
			reply        = (cur.stage == ST_ENTRY) ? 16'h0000 : nxt.recv_shift;
			nxt.stage    = ST_IDLE;
			nxt.phase    = '0;
			nxt.bit_idx  = '0;
			nxt.byte_idx = '0;
		end

		res.reset_pin   = nxt.reset_level;
		res.clock_pin   = nxt.clock_level;
		res.data_pin    = nxt.data_level;
		res.data_drive  = nxt.drive_enable;
		res.busy_res    = (nxt.stage != ST_IDLE);
		res.reply_valid = done;
		res.reply       = reply;
	end

endmodule

// ===== rtl/two_wire_debug_master.sv =====
// ----------------------------------------------------------------------------
// two_wire_debug_master
// Two-wire debug master: entry sequence, debug commands and reply readback.
// ----------------------------------------------------------------------------
// Takes one item per clock while no result waits on out_ready and returns one
// result per item; each item passes the input register, then the result
// register. While a result waits on out_ready the input register holds at
// most one more item and in_ready then drops. Pin timing comes from tick
// items: each pin phase lasts ticks_per_phase ticks, a bit takes three phases.
// A command item starts a sequence only when busy_res is low; reply_valid
// marks the item that ends a sequence. Write ticks_per_phase only while idle.
module two_wire_debug_master import twdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data
);

	twdm_state_t state_q;
	twdm_state_t state_nxt;
	in_item_t    item_s1;
	logic        item_valid_s1;
	out_item_t   out_item_q;
	out_item_t   res;
	logic        out_valid_q;
	logic [7:0]  ticks_q;
	logic        step;

	twdm_step u_step (
		.cur   (state_q),
		.ticks (ticks_q),
		.item  (item_s1),
		.nxt   (state_nxt),
		.res   (res)
	);

	assign step      = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !item_valid_s1 || step;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= 8'd1;
		end else if (cfg_valid) begin
			ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
			state_q       <= STATE_RESET;
		end else begin
			if (in_ready) begin
				item_valid_s1 <= in_valid;
			end
			if (step) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (step) begin
			out_item_q <= res;
		end
	end

endmodule
